[hw/rtl/xerd_pkg.sv]
// ---------------------------------------------------------------------------
// xerd_pkg - shared definitions for the xml entity reference decoder
// character codes, code point limits, control structs and utf-8 helpers
// ---------------------------------------------------------------------------
`default_nettype none

package xerd_pkg;

   localparam int unsigned REF_BYTES_DEF = 16;

   localparam int unsigned CP_W  = 21;
   localparam int unsigned SUM_W = 25;

   localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;
   localparam logic [CP_W-1:0] SUR_LO = 21'h00D800;
   localparam logic [CP_W-1:0] SUR_HI = 21'h00DFFF;

   localparam logic [7:0] UTF_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF_LEAD3 = 8'hE0;
   localparam logic [7:0] UTF_LEAD4 = 8'hF0;
   localparam logic [7:0] UTF_CONT  = 8'h80;
   localparam logic [5:0] UTF_MASK  = 6'h3F;

   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_QUOT  = 8'h22;
   localparam logic [7:0] CH_APOS  = 8'h27;

   // command into the code point unit
   typedef struct packed {
      logic clear;
      logic step;
      logic hex;
   } xerd_cp_cmd_type;

   // status back from the code point unit
   typedef struct packed {
      logic            digit_ok;
      logic            over;
      logic            final_bad;
      logic [CP_W-1:0] cp;
   } xerd_cp_status_type;

   function automatic logic is_name_byte(input logic [7:0] c);
      is_name_byte = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
                     (c >= "0" && c <= "9") || c == "_" || c == "-" ||
                     c == "." || c == ":";
   endfunction

   // number of utf-8 bytes minus one
   function automatic logic [1:0] utf8_len(input logic [CP_W-1:0] cp);
      if (cp < 21'h80) begin
         utf8_len = 2'd0;
      end else if (cp < 21'h800) begin
         utf8_len = 2'd1;
      end else if (cp < 21'h10000) begin
         utf8_len = 2'd2;
      end else begin
         utf8_len = 2'd3;
      end
   endfunction

   function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                            input logic [1:0] nm1,
                                            input logic [1:0] k);
      logic [5:0] c0;
      logic [5:0] c1;
      logic [5:0] c2;
      c0 = cp[5:0] & UTF_MASK;
      c1 = cp[11:6] & UTF_MASK;
      c2 = cp[17:12] & UTF_MASK;
      case (nm1)
         2'd0: utf8_byte = cp[7:0];
         2'd1: utf8_byte = (k == 2'd0) ? (UTF_LEAD2 | {3'b000, cp[10:6]})
                                       : (UTF_CONT | {2'b00, c0});
         2'd2: begin
            case (k)
               2'd0:    utf8_byte = UTF_LEAD3 | {4'b0000, cp[15:12]};
               2'd1:    utf8_byte = UTF_CONT | {2'b00, c1};
               default: utf8_byte = UTF_CONT | {2'b00, c0};
            endcase
         end
         default: begin
            case (k)
               2'd0:    utf8_byte = UTF_LEAD4 | {5'b00000, cp[20:18]};
               2'd1:    utf8_byte = UTF_CONT | {2'b00, c2};
               2'd2:    utf8_byte = UTF_CONT | {2'b00, c1};
               default: utf8_byte = UTF_CONT | {2'b00, c0};
            endcase
         end
      endcase
   endfunction

endpackage

`default_nettype wire

[hw/rtl/xml_entity_reference_decoder.sv]
// ---------------------------------------------------------------------------
// xml_entity_reference_decoder - xml character reference decoder, utf-8 out
// expands &amp; &lt; &gt; &quot; &apos; and numeric references in a byte stream
// ---------------------------------------------------------------------------
// Every input beat carries one text byte (req_tdata) or a flush (req_tuser).
// Ordinary bytes come out unchanged. A '&' opens a reference whose name bytes
// are held in a small register store, with no output. On ';' the five
// predefined names give one byte; '#' decimal and '#x' hex references are
// evaluated by one shared multiply-add unit, one stored digit per cycle, and
// then leave as 1 to 4 utf-8 bytes. Anything that cannot be decoded (empty,
// unknown, malformed, too long, out of range, surrogate, zero, broken by
// another byte or by flush) is replayed raw at one byte per cycle while the
// output is ready: '&', the stored bytes, and ';' when it was present.
// Output runs of one input beat end with rsp_tlast. The input is not ready
// while a beat is being worked on; rsp_tready low stalls the output
// sequencer.
`default_nettype none

module xml_entity_reference_decoder
   import xerd_pkg::*;
#(
   parameter int unsigned REF_BYTES = REF_BYTES_DEF
)(
   input  wire logic       clock,
   input  wire logic       reset,

   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_byte
   input  wire logic       req_tuser,   // [0] flush

   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic            rsp_tlast    // last
);

   localparam int unsigned CW = $clog2(REF_BYTES + 1);
   localparam int unsigned IW = $clog2(REF_BYTES);

   // sequencer states, one-hot
   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,   // take a beat
      S_AMP  = 6'b000010,   // raw replay: the '&'
      S_RAW  = 6'b000100,   // raw replay: stored bytes
      S_TAIL = 6'b001000,   // single byte: ';', copied byte or entity
      S_NUM  = 6'b010000,   // one digit per cycle into the code point unit
      S_UTF  = 6'b100000    // utf-8 bytes of the code point
   } state_type;

   state_type state_ff, state_in;

   logic          in_ref_ff, in_ref_in;        // a reference is open
   logic [CW-1:0] count_ff, count_in;          // stored reference bytes
   logic [IW-1:0] ptr_ff, ptr_in;              // store read pointer
   logic          tail_en_ff, tail_en_in;      // raw replay ends with tail byte
   logic          open_after_ff, open_after_in;// reopen a reference when done
   logic [7:0]    tail_ff, tail_in;
   logic [1:0]    utf_k_ff, utf_k_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_data_ff, rsp_data_in;
   logic          rsp_last_ff, rsp_last_in;

   logic [7:0]    ref_store_ff [REF_BYTES];
   logic          store_we;

   xerd_cp_cmd_type    cp_cmd;
   xerd_cp_status_type cp_stat;

   logic          accept;
   logic          out_free;
   logic          ptr_last;
   logic [7:0]    rd_byte;
   logic          is_hex;
   logic [IW-1:0] num_start;
   logic [1:0]    utf_nm1;
   logic          hit_amp, hit_lt, hit_gt, hit_quot, hit_apos;

   xerd_cp_unit u_cp (
      .clock      (clock),
      .cmd        (cp_cmd),
      .digit_byte (rd_byte),
      .status     (cp_stat)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // output register may be loaded when empty or drained this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign rd_byte  = ref_store_ff[ptr_ff];
   assign ptr_last = (CW'(ptr_ff) + CW'(1)) == count_ff;
   assign utf_nm1  = utf8_len(cp_stat.cp);

   // predefined names, checked on the first stored bytes
   assign hit_amp  = count_ff == CW'(3) && ref_store_ff[0] == "a" &&
                     ref_store_ff[1] == "m" && ref_store_ff[2] == "p";
   assign hit_lt   = count_ff == CW'(2) && ref_store_ff[0] == "l" &&
                     ref_store_ff[1] == "t";
   assign hit_gt   = count_ff == CW'(2) && ref_store_ff[0] == "g" &&
                     ref_store_ff[1] == "t";
   assign hit_quot = count_ff == CW'(4) && ref_store_ff[0] == "q" &&
                     ref_store_ff[1] == "u" && ref_store_ff[2] == "o" &&
                     ref_store_ff[3] == "t";
   assign hit_apos = count_ff == CW'(4) && ref_store_ff[0] == "a" &&
                     ref_store_ff[1] == "p" && ref_store_ff[2] == "o" &&
                     ref_store_ff[3] == "s";

   assign is_hex    = count_ff > CW'(1) &&
                      (ref_store_ff[1] == "x" || ref_store_ff[1] == "X");
   assign num_start = is_hex ? IW'(2) : IW'(1);

   always_comb begin
      state_in      = state_ff;
      in_ref_in     = in_ref_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      tail_en_in    = tail_en_ff;
      open_after_in = open_after_ff;
      tail_in       = tail_ff;
      utf_k_in      = utf_k_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      store_we      = 1'b0;
      cp_cmd        = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ptr_in = '0;
               if (req_tuser) begin
                  if (in_ref_ff) begin
                     tail_en_in    = 1'b0;
                     open_after_in = 1'b0;
                     state_in      = S_AMP;
                  end
               end else if (in_ref_ff) begin
                  open_after_in = 1'b0;
                  if (req_tdata == CH_SEMI) begin
                     tail_in    = CH_SEMI;
                     tail_en_in = 1'b1;
                     if (count_ff == '0) begin
                        state_in = S_AMP;
                     end else if (hit_amp) begin
                        tail_in  = CH_AMP;
                        state_in = S_TAIL;
                     end else if (hit_lt) begin
                        tail_in  = CH_LT;
                        state_in = S_TAIL;
                     end else if (hit_gt) begin
                        tail_in  = CH_GT;
                        state_in = S_TAIL;
                     end else if (hit_quot) begin
                        tail_in  = CH_QUOT;
                        state_in = S_TAIL;
                     end else if (hit_apos) begin
                        tail_in  = CH_APOS;
                        state_in = S_TAIL;
                     end else if (ref_store_ff[0] != CH_HASH ||
                                  count_ff <= CW'(num_start)) begin
                        state_in = S_AMP;
                     end else begin
                        cp_cmd.clear = 1'b1;
                        cp_cmd.hex   = is_hex;
                        ptr_in       = num_start;
                        state_in     = S_NUM;
                     end
                  end else if ((is_name_byte(req_tdata) || req_tdata == CH_HASH) &&
                               count_ff < CW'(REF_BYTES)) begin
                     store_we = 1'b1;
                     count_in = count_ff + CW'(1);
                  end else begin
                     // breaking byte: replay raw, then handle the byte
                     open_after_in = (req_tdata == CH_AMP);
                     tail_en_in    = (req_tdata != CH_AMP);
                     tail_in       = req_tdata;
                     state_in      = S_AMP;
                  end
               end else if (req_tdata == CH_AMP) begin
                  in_ref_in = 1'b1;
                  count_in  = '0;
               end else begin
                  tail_in       = req_tdata;
                  open_after_in = 1'b0;
                  state_in      = S_TAIL;
               end
            end
         end

         S_AMP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = CH_AMP;
               rsp_last_in  = (count_ff == '0) && !tail_en_ff;
               if (count_ff != '0) begin
                  state_in = S_RAW;
               end else if (tail_en_ff) begin
                  state_in = S_TAIL;
               end else begin
                  state_in  = S_IDLE;
                  in_ref_in = open_after_ff;
                  count_in  = '0;
               end
            end
         end

         S_RAW: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rd_byte;
               rsp_last_in  = ptr_last && !tail_en_ff;
               if (!ptr_last) begin
                  ptr_in = ptr_ff + IW'(1);
               end else if (tail_en_ff) begin
                  state_in = S_TAIL;
               end else begin
                  state_in  = S_IDLE;
                  in_ref_in = open_after_ff;
                  count_in  = '0;
               end
            end
         end

         S_TAIL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = tail_ff;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
               in_ref_in    = open_after_ff;
               count_in     = '0;
            end
         end

         S_NUM: begin
            cp_cmd.step = 1'b1;
            if (!cp_stat.digit_ok || cp_stat.over ||
                (ptr_last && cp_stat.final_bad)) begin
               // not a usable number: replay raw with ';'
               ptr_in     = '0;
               tail_in    = CH_SEMI;
               tail_en_in = 1'b1;
               state_in   = S_AMP;
            end else if (ptr_last) begin
               utf_k_in = 2'd0;
               state_in = S_UTF;
            end else begin
               ptr_in = ptr_ff + IW'(1);
            end
         end

         S_UTF: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = utf8_byte(cp_stat.cp, utf_nm1, utf_k_ff);
               rsp_last_in  = (utf_k_ff == utf_nm1);
               if (utf_k_ff == utf_nm1) begin
                  state_in  = S_IDLE;
                  in_ref_in = 1'b0;
                  count_in  = '0;
               end else begin
                  utf_k_in = utf_k_ff + 2'd1;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         in_ref_ff     <= 1'b0;
         count_ff      <= '0;
         ptr_ff        <= '0;
         tail_en_ff    <= 1'b0;
         open_after_ff <= 1'b0;
         utf_k_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         in_ref_ff     <= in_ref_in;
         count_ff      <= count_in;
         ptr_ff        <= ptr_in;
         tail_en_ff    <= tail_en_in;
         open_after_ff <= open_after_in;
         utf_k_ff      <= utf_k_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      tail_ff     <= tail_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (store_we) begin
         ref_store_ff[count_ff[IW-1:0]] <= req_tdata;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/xerd_cp_unit.sv]
// ---------------------------------------------------------------------------
// xerd_cp_unit - shared code point accumulator
// one digit per step: cp = cp * base + digit, with range and validity flags
// ---------------------------------------------------------------------------
`default_nettype none

module xerd_cp_unit
   import xerd_pkg::*;
(
   input  wire logic               clock,
   input  wire xerd_cp_cmd_type    cmd,
   input  wire logic [7:0]         digit_byte,
   output xerd_cp_status_type      status
);

   logic [CP_W-1:0]  cp_ff;
   logic             hex_ff;
   logic [3:0]       digit_val;
   logic             digit_ok;
   logic [SUM_W-1:0] opnd_a;
   logic [SUM_W-1:0] opnd_b;
   logic [SUM_W-1:0] sum;

   // digit decode
   always_comb begin
      digit_ok  = 1'b0;
      digit_val = 4'd0;
      if (digit_byte >= "0" && digit_byte <= "9") begin
         digit_ok  = 1'b1;
         digit_val = 4'(digit_byte - "0");
      end else if (hex_ff && digit_byte >= "a" && digit_byte <= "f") begin
         digit_ok  = 1'b1;
         digit_val = 4'(digit_byte - "a" + 8'd10);
      end else if (hex_ff && digit_byte >= "A" && digit_byte <= "F") begin
         digit_ok  = 1'b1;
         digit_val = 4'(digit_byte - "A" + 8'd10);
      end
   end

   // times 16, or times 10 as 8x + 2x, through one adder
   assign opnd_a = hex_ff ? {cp_ff, 4'b0000} : {1'b0, cp_ff, 3'b000};
   assign opnd_b = hex_ff ? '0 : {3'b000, cp_ff, 1'b0};
   assign sum    = opnd_a + opnd_b + {{(SUM_W-4){1'b0}}, digit_val};

   assign status.digit_ok  = digit_ok;
   assign status.over      = sum > {{(SUM_W-CP_W){1'b0}}, CP_MAX};
   assign status.final_bad = (sum == '0) ||
                             (sum >= {{(SUM_W-CP_W){1'b0}}, SUR_LO} &&
                              sum <= {{(SUM_W-CP_W){1'b0}}, SUR_HI});
   assign status.cp        = cp_ff;

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         cp_ff  <= '0;
         hex_ff <= cmd.hex;
      end else if (cmd.step) begin
         cp_ff  <= sum[CP_W-1:0];
      end
   end

endmodule

`default_nettype wire
